// File: src/kmhn_pkg.sv
// Package for the k-mer Hamming neighbor generator: shared types, codes and constants.
// Used by kmhn_cfg, kmhn_step and kmer_hamming_neighbor_generator; depends on nothing.
package kmhn_pkg;

    // Sizes of the k-mer and of the fields.
    localparam int MAX_KMER_LENGTH = 16;
    localparam int NUM_POS         = 16;
    localparam int KMER_W          = 32;
    localparam int DIST_W          = 5;
    localparam int CFG_W           = 5;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 40;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // Two bits per base.
    localparam logic [1:0] BASE_BITS = 2'b11;
    localparam logic [1:0] BASE_A    = 2'b00;
    localparam logic [1:0] BASE_C    = 2'b01;

    // Register indexes on the configuration port.
    localparam logic REG_KMER_LENGTH  = 1'b0;
    localparam logic REG_MAX_DISTANCE = 1'b1;

    // Register reset values.
    localparam logic [CFG_W-1:0] KMER_LENGTH_RST  = 5'd8;
    localparam logic [CFG_W-1:0] MAX_DISTANCE_RST = 5'd2;

    // Item kinds carried on the input tuser.
    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_NEXT  = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [CFG_W-1:0] kmer_length;
        logic [CFG_W-1:0] max_distance;
    } cfg_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [KMER_W-1:0] kmer;
    } item_t;

    // Enumeration state; describes the pending, not yet emitted, neighbor.
    // The substitution code is kept per position: digit p sits in bits 2p+1:2p.
    typedef struct packed
    {
        logic [KMER_W-1:0]  base_kmer;
        logic [DIST_W-1:0]  layer_distance;
        logic [NUM_POS-1:0] position_mask;
        logic [KMER_W-1:0]  subst_code;
        logic               finished;
    } state_t;

    typedef struct packed
    {
        logic [KMER_W-1:0] neighbor;
        logic [DIST_W-1:0] distance;
        logic              last;
        logic              valid_res;
    } result_t;

    localparam state_t STATE_RESET = '{
        base_kmer:      '0,
        layer_distance: '0,
        position_mask:  '0,
        subst_code:     '0,
        finished:       1'b1
    };

endpackage

// File: src/kmhn_cfg.sv
// Configuration registers of the k-mer neighbor generator behind an APB-style port.
// Depends on kmhn_pkg.
module kmhn_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kmhn_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [kmhn_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kmhn_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output kmhn_pkg::cfg_t                    cfg
);
    import kmhn_pkg::*;

    logic             wr_en;
    logic             reg_sel;
    logic [CFG_W-1:0] kmer_length_reg;
    logic [CFG_W-1:0] max_distance_reg;

    // Registers are word aligned; the low address bits select nothing.
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg  <= KMER_LENGTH_RST;
            max_distance_reg <= MAX_DISTANCE_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_KMER_LENGTH:  kmer_length_reg  <= pwdata[CFG_W-1:0];
                REG_MAX_DISTANCE: max_distance_reg <= pwdata[CFG_W-1:0];
                default:          kmer_length_reg  <= kmer_length_reg;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        case (reg_sel)
            REG_KMER_LENGTH:  prdata = APB_DATA_W'(kmer_length_reg);
            REG_MAX_DISTANCE: prdata = APB_DATA_W'(max_distance_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.kmer_length  = kmer_length_reg;
    assign cfg.max_distance = max_distance_reg;

endmodule

// File: src/kmhn_step.sv
// One enumeration step: result and next state from the current state and one item.
// Pure combinational logic; depends on kmhn_pkg.
module kmhn_step
(
    input  kmhn_pkg::cfg_t    cfg,
    input  kmhn_pkg::state_t  st,
    input  kmhn_pkg::item_t   item,
    output kmhn_pkg::state_t  st_next,
    output kmhn_pkg::result_t res
);
    import kmhn_pkg::*;

    // Lowest valid code for a mask: each selected base goes to A, or to C if it was A.
    function automatic logic [KMER_W-1:0] first_code(input logic [NUM_POS-1:0] mask,
                                                     input logic [KMER_W-1:0]  base);
        logic [KMER_W-1:0] code;
        code = '0;
        for (int p = 0; p < NUM_POS; p++)
        begin
            if (mask[p] && base[2*p +: 2] == BASE_A)
            begin
                code[2*p +: 2] = BASE_C;
            end
        end
        return code;
    endfunction

    // Opens the first non-empty layer at or below distance l_in.
    function automatic state_t open_layer(input logic [DIST_W-1:0] l_in,
                                          input logic [DIST_W-1:0] k,
                                          input logic [KMER_W-1:0] base);
        state_t             s;
        logic [DIST_W-1:0]  l;
        logic [NUM_POS-1:0] mask;
        l    = (l_in > k) ? k : l_in;
        mask = '0;
        for (int p = 0; p < NUM_POS; p++)
        begin
            mask[p] = (DIST_W'(p) < l);
        end
        s.base_kmer = base;
        if (l == '0)
        begin
            s.layer_distance = '0;
            s.position_mask  = '0;
            s.subst_code     = '0;
            s.finished       = 1'b1;
        end
        else
        begin
            s.layer_distance = l;
            s.position_mask  = mask;
            s.subst_code     = first_code(mask, base);
            s.finished       = 1'b0;
        end
        return s;
    endfunction

    logic [DIST_W-1:0]   k_eff;
    logic [KMER_W-1:0]   base_load;
    state_t              start_st;
    logic [KMER_W-1:0]   built;
    logic [2:0]          nd_a   [NUM_POS];
    logic [2:0]          nd     [NUM_POS];
    logic [NUM_POS:0]    carry;
    logic [KMER_W-1:0]   code_inc;
    logic                code_ok;
    logic [NUM_POS-1:0]  g_t;
    logic [NUM_POS:0]    g_t1;
    logic [NUM_POS:0]    g_lz;
    logic [DIST_W-1:0]   g_ctz;
    logic [DIST_W-1:0]   g_sh;
    logic [NUM_POS:0]    g_mask;
    logic [NUM_POS:0]    g_limit;
    logic                gosper_ok;
    state_t              adv_st;

    // Saturate the length register.
    assign k_eff = (cfg.kmer_length > DIST_W'(MAX_KMER_LENGTH)) ?
                   DIST_W'(MAX_KMER_LENGTH) : cfg.kmer_length;

    // Load path: clear bases at or above the length, then open the top layer.
    always_comb
    begin
        for (int p = 0; p < NUM_POS; p++)
        begin
            base_load[2*p +: 2] = (DIST_W'(p) < k_eff) ? item.kmer[2*p +: 2] : 2'b00;
        end
        start_st = open_layer(cfg.max_distance, k_eff, base_load);
    end

    // Pending neighbor: selected positions take their code digit.
    always_comb
    begin
        for (int p = 0; p < NUM_POS; p++)
        begin
            built[2*p +: 2] = st.position_mask[p] ? st.subst_code[2*p +: 2]
                                                   : st.base_kmer[2*p +: 2];
        end
    end

    // Next code: increment the lowest selected digit, skipping the original base,
    // and carry into the next selected position when a digit runs past T.
    always_comb
    begin
        carry[0] = 1'b1;
        for (int p = 0; p < NUM_POS; p++)
        begin
            nd_a[p] = {1'b0, st.subst_code[2*p +: 2]} + 3'd1;
            nd[p]   = (nd_a[p] == {1'b0, st.base_kmer[2*p +: 2]}) ? nd_a[p] + 3'd1 : nd_a[p];
            if (st.position_mask[p] && carry[p])
            begin
                code_inc[2*p +: 2] = nd[p][2] ?
                    ((st.base_kmer[2*p +: 2] == BASE_A) ? BASE_C : BASE_A) : nd[p][1:0];
            end
            else
            begin
                code_inc[2*p +: 2] = st.subst_code[2*p +: 2];
            end
            carry[p+1] = carry[p] & (~st.position_mask[p] | nd[p][2]);
        end
        code_ok = ~carry[NUM_POS];
    end

    // Next mask of the same weight (Gosper's step), checked against the length.
    always_comb
    begin
        g_ctz = DIST_W'(NUM_POS);
        for (int p = NUM_POS - 1; p >= 0; p--)
        begin
            if (st.position_mask[p])
            begin
                g_ctz = DIST_W'(p);
            end
        end
        g_t       = st.position_mask | (st.position_mask - 16'd1);
        g_t1      = {1'b0, g_t} + 17'd1;
        g_lz      = ~{1'b0, g_t} & g_t1;
        g_sh      = g_ctz + 5'd1;
        g_mask    = g_t1 | ((g_lz - 17'd1) >> g_sh);
        g_limit   = 17'd1 << k_eff;
        gosper_ok = (g_mask < g_limit) && (st.position_mask != '0);
    end

    // State after emitting the pending neighbor.
    always_comb
    begin
        adv_st = st;
        if (code_ok)
        begin
            adv_st.subst_code = code_inc;
        end
        else if (gosper_ok)
        begin
            adv_st.position_mask = g_mask[NUM_POS-1:0];
            adv_st.subst_code    = first_code(g_mask[NUM_POS-1:0], st.base_kmer);
        end
        else
        begin
            adv_st = open_layer(st.layer_distance - 5'd1, k_eff, st.base_kmer);
        end
    end

    // Result and next state by item kind.
    always_comb
    begin
        case (item.kind)
            KIND_START:
            begin
                st_next       = start_st;
                res.neighbor  = base_load;
                res.distance  = '0;
                res.last      = start_st.finished;
                res.valid_res = 1'b1;
            end
            KIND_NEXT:
            begin
                if (st.finished)
                begin
                    st_next       = st;
                    res.neighbor  = '0;
                    res.distance  = '0;
                    res.last      = 1'b1;
                    res.valid_res = 1'b0;
                end
                else
                begin
                    st_next       = adv_st;
                    res.neighbor  = built;
                    res.distance  = st.layer_distance;
                    res.last      = adv_st.finished;
                    res.valid_res = 1'b1;
                end
            end
            default:
            begin
                st_next       = st;
                res.neighbor  = '0;
                res.distance  = '0;
                res.last      = 1'b1;
                res.valid_res = 1'b0;
            end
        endcase
    end

endmodule

// File: src/kmer_hamming_neighbor_generator.sv
// Top level of the DNA k-mer Hamming neighbor generator: stream ports, APB registers.
// Depends on kmhn_pkg, kmhn_cfg and kmhn_step.
//
// A start transfer (tuser 0) loads a k-mer, two bits per base with base i in bits
// 2i+1:2i, and returns it at distance 0; each next transfer (tuser 1) returns one
// neighbor, layers running from max_distance down to 1, masks ascending within a layer
// and substitutions ascending within a mask. tlast marks the final neighbor, and a next
// after the end returns tuser 0 with zero data. The block takes one transfer per clock
// cycle unless the output stalls; each result passes an input register, then one
// combinational step that updates the enumeration state, then the result register. That
// single step, a carry chain over the 16 positions for the next code and the mask step,
// sets the clock rate. Registers sit at byte addresses 0 (kmer_length) and 4
// (max_distance); the user must write them only while the block is idle (not enforced).
module kmer_hamming_neighbor_generator
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [kmhn_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [31:0] kmer
    input  logic                               s_axis_tuser,  // [0] kind
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [kmhn_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [31:0] neighbor, [36:32] distance
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser,  // [0] valid_res
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kmhn_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kmhn_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kmhn_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import kmhn_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    logic    out_free;
    logic    fire;

    kmhn_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kmhn_step u_step
    (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    // Handshake: the result register frees when empty or taken; the input register
    // frees whenever its item moves on.
    assign out_free       = ~out_valid_reg | m_axis_tready;
    assign fire           = in_valid_reg & out_free;
    assign s_axis_tready  = ~in_valid_reg | out_free;
    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Control and enumeration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind <= kind_t'(s_axis_tuser);
            in_item_reg.kmer <= s_axis_tdata;
        end
        if (fire)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.distance, out_res_reg.neighbor};
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tuser  = out_res_reg.valid_res;

    // A finished enumeration holds no pending mask or layer.
    a_finished_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.finished |-> (state_reg.position_mask == '0 &&
                                state_reg.layer_distance == '0))
        else $error("finished state still holds a mask or layer");

    // A pending mask always has as many positions as its layer distance.
    a_mask_weight: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.finished |->
            ($countones(state_reg.position_mask) == 32'(state_reg.layer_distance)))
        else $error("mask weight differs from layer distance");

    // An invalid result is always the empty, final one.
    a_invalid_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("invalid result carries data");

    // An item waiting on a full result register is not lost.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("input item dropped while the output stalled");

endmodule

// File: dv/tb.sv
// Testbench for kmer_hamming_neighbor_generator: drives start and next transfers,
// writes and reads back the APB registers, and checks each result against a predictor.
// Depends on kmhn_pkg and the RTL of kmer_hamming_neighbor_generator only.
`timescale 1ns / 100ps

module tb;

    import kmhn_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] kmer
    logic                  s_axis_tuser = 1'b0; // [0] kind

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // [31:0] neighbor, [36:32] distance
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;        // [0] valid_res

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Register copies and the walk state of the neighborhood predictor.
    logic [CFG_W-1:0]  cfg_kmer_length = KMER_LENGTH_RST;
    logic [CFG_W-1:0]  cfg_max_distance = MAX_DISTANCE_RST;
    logic [KMER_W-1:0] walk_base = '0;
    logic [31:0]       walk_layer = '0;
    logic [31:0]       walk_mask = '0;
    logic [31:0]       walk_code = '0;
    bit                walk_done = 1'b1;

    result_t pending_neighbors[$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      ready_hold = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b1;

    kmer_hamming_neighbor_generator DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Neighborhood predictor.
    // ------------------------------------------------------------------

    function automatic int unsigned active_length();
        return (cfg_kmer_length > CFG_W'(MAX_KMER_LENGTH)) ? MAX_KMER_LENGTH
                                                           : 32'(cfg_kmer_length);
    endfunction

    function automatic logic [1:0] loaded_base(input int p);
        return walk_base[2*p +: 2];
    endfunction

    // Smallest substitution for a mask: every selected base moves to A, or to C if it was A.
    function automatic logic [31:0] lowest_code(input logic [31:0] mask);
        logic [31:0] code;
        int          j;
        int          p;
        code = '0;
        j = 0;
        for (p = 0; p < NUM_POS; p++)
        begin
            if (mask[p])
            begin
                code[2*j +: 2] = (loaded_base(p) == BASE_A) ? BASE_C : BASE_A;
                j++;
            end
        end
        return code;
    endfunction

    // Counts the code up, digit by digit, skipping the loaded base; 0 when it wraps.
    function automatic bit bump_code(input logic [31:0] mask, inout logic [31:0] code);
        logic [31:0] c;
        logic [1:0]  orig;
        logic [2:0]  digit;
        int          j;
        int          p;
        c = code;
        j = 0;
        for (p = 0; p < NUM_POS; p++)
        begin
            if (mask[p])
            begin
                orig = loaded_base(p);
                digit = {1'b0, c[2*j +: 2]} + 3'd1;
                if (digit == {1'b0, orig})
                    digit = digit + 3'd1;
                if (digit <= 3'd3)
                begin
                    c[2*j +: 2] = digit[1:0];
                    code = c;
                    return 1'b1;
                end
                c[2*j +: 2] = (orig == BASE_A) ? BASE_C : BASE_A;
                j++;
            end
        end
        code = c;
        return 1'b0;
    endfunction

    // Next larger mask with the same number of ones.
    function automatic logic [31:0] next_mask(input logic [31:0] m);
        logic [31:0] t;
        logic [31:0] nt;
        logic [31:0] low_bit;
        int          zeros;
        zeros = 0;
        while (zeros < 31 && !m[zeros])
            zeros++;
        t = m | (m - 32'd1);
        nt = ~t;
        low_bit = nt & (32'd0 - nt);
        return (t + 32'd1) | ((low_bit - 32'd1) >> (zeros + 1));
    endfunction

    // Opens the first non-empty layer at or below the given distance.
    function automatic void open_layer(input logic [31:0] layer);
        logic [31:0] l;
        l = layer;
        if (l > active_length())
            l = active_length();
        if (l == 0)
        begin
            walk_done = 1'b1;
            walk_layer = '0;
            walk_mask = '0;
            walk_code = '0;
        end
        else
        begin
            walk_layer = l;
            walk_mask = (32'd1 << l) - 32'd1;
            walk_code = lowest_code(walk_mask);
            walk_done = 1'b0;
        end
    endfunction

    function automatic void advance_walk();
        logic [31:0] code;
        logic [31:0] m;
        code = walk_code;
        if (bump_code(walk_mask, code))
        begin
            walk_code = code;
            return;
        end
        m = next_mask(walk_mask);
        if (m < (32'd1 << active_length()) && walk_mask != 0)
        begin
            walk_mask = m;
            walk_code = lowest_code(m);
            return;
        end
        open_layer(walk_layer - 32'd1);
    endfunction

    function automatic logic [KMER_W-1:0] substituted_kmer();
        logic [KMER_W-1:0] v;
        int                j;
        int                p;
        v = walk_base;
        j = 0;
        for (p = 0; p < NUM_POS; p++)
        begin
            if (walk_mask[p])
            begin
                v[2*p +: 2] = walk_code[2*j +: 2];
                j++;
            end
        end
        return v;
    endfunction

    // Result of one accepted item; moves the walk on.
    function automatic result_t next_neighbor_result(input kind_t kind,
                                                     input logic [KMER_W-1:0] kmer);
        result_t     r;
        logic [63:0] keep;
        if (kind == KIND_START)
        begin
            keep = (64'd1 << (2 * active_length())) - 64'd1;
            walk_base = kmer & keep[KMER_W-1:0];
            r.neighbor = walk_base;
            r.distance = '0;
            open_layer({27'd0, cfg_max_distance});
            r.last = walk_done;
            r.valid_res = 1'b1;
        end
        else if (walk_done)
        begin
            r.neighbor = '0;
            r.distance = '0;
            r.last = 1'b1;
            r.valid_res = 1'b0;
        end
        else
        begin
            r.neighbor = substituted_kmer();
            r.distance = walk_layer[DIST_W-1:0];
            advance_walk();
            r.last = walk_done;
            r.valid_res = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KMER_W-1:0] pick_kmer();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Sends one item and records the result it must produce.
    task automatic send_item(input kind_t kind, input logic [KMER_W-1:0] kmer);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= kmer;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_neighbors.push_back(next_neighbor_result(kind, kmer));
        items_sent++;
    endtask

    // Stops the input stream and lets every expected result come back.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] upper;
        upper = $urandom;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {upper[APB_DATA_W-1:CFG_W], value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_KMER_LENGTH)
            cfg_kmer_length = value;
        else
            cfg_max_distance = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(input logic idx);
        logic [APB_DATA_W-1:0] want;
        want = (idx == REG_KMER_LENGTH) ? APB_DATA_W'(cfg_kmer_length)
                                        : APB_DATA_W'(cfg_max_distance);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report_mismatch((idx == REG_KMER_LENGTH) ? "kmer_length read" : "max_distance read",
                            40'(prdata), 40'(want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] klen, input logic [CFG_W-1:0] dmax);
        write_reg(REG_KMER_LENGTH, klen);
        write_reg(REG_MAX_DISTANCE, dmax);
    endtask

    // ------------------------------------------------------------------
    // Result checking and output stalls.
    // ------------------------------------------------------------------

    task automatic check_result();
        result_t want;
        if (pending_neighbors.size() == 0)
        begin
            report_mismatch("unexpected result", m_axis_tdata, '0);
            return;
        end
        want = pending_neighbors.pop_front();
        if (m_axis_tdata[KMER_W-1:0] !== want.neighbor)
            report_mismatch("neighbor", 40'(m_axis_tdata[KMER_W-1:0]), 40'(want.neighbor));
        if (m_axis_tdata[KMER_W +: DIST_W] !== want.distance)
            report_mismatch("distance", 40'(m_axis_tdata[KMER_W +: DIST_W]),
                            40'(want.distance));
        if (m_axis_tlast !== want.last)
            report_mismatch("last", 40'(m_axis_tlast), 40'(want.last));
        if (m_axis_tuser !== want.valid_res)
            report_mismatch("valid_res", 40'(m_axis_tuser), 40'(want.valid_res));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    // The receiver stalls in bursts of random length.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // Watchdog: too long without any transfer ends the run.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Registers come up at their reset values and a next with nothing loaded is invalid.
    task automatic test_next_before_start();
        read_reg(REG_KMER_LENGTH);
        read_reg(REG_MAX_DISTANCE);
        send_item(KIND_NEXT, '1);
        send_item(KIND_NEXT, $urandom);
        wait_idle();
    endtask

    // Every register holds the written value, extremes included.
    task automatic test_register_access();
        logic [CFG_W-1:0] values[4];
        int               i;
        values = '{5'd0, 5'd31, 5'd16, CFG_W'($urandom)};
        for (i = 0; i < 4; i++)
        begin
            write_reg(REG_KMER_LENGTH, values[i]);
            read_reg(REG_KMER_LENGTH);
            write_reg(REG_MAX_DISTANCE, values[3 - i]);
            read_reg(REG_MAX_DISTANCE);
        end
    endtask

    // A single base with a distance far beyond it; stray high bits are cleared on load.
    task automatic test_single_base_wide_distance();
        set_config(5'd1, 5'd31);
        send_item(KIND_START, '1);
        repeat (4) send_item(KIND_NEXT, $urandom);
        wait_idle();
    endtask

    // A zero length leaves only the cleared k-mer itself.
    task automatic test_zero_length();
        set_config(5'd0, 5'd2);
        send_item(KIND_START, 32'hA5A5_5A5A);
        send_item(KIND_NEXT, '0);
        wait_idle();
    endtask

    // A length above the maximum saturates; distance zero ends at once.
    task automatic test_saturated_length();
        set_config(5'd31, 5'd0);
        send_item(KIND_START, '1);
        send_item(KIND_NEXT, '1);
        wait_idle();
    endtask

    task automatic test_full_length_all_a();
        set_config(5'd16, 5'd1);
        send_item(KIND_START, '0);
        repeat (3) send_item(KIND_NEXT, '0);
        wait_idle();
    endtask

    // New settings between steps govern the search for the neighbor after the pending one.
    task automatic test_settings_changed_mid_run();
        set_config(5'd3, 5'd3);
        send_item(KIND_START, $urandom);
        repeat (3) send_item(KIND_NEXT, $urandom);
        wait_idle();
        set_config(5'd2, 5'd1);
        repeat (4) send_item(KIND_NEXT, $urandom);
        wait_idle();
    endtask

    // Random settings, each with several start runs; most runs walk to the end.
    task automatic test_random_runs();
        int               target;
        int               cap;
        int               steps;
        logic [CFG_W-1:0] klen;
        logic [CFG_W-1:0] dmax;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            wait_idle();
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    klen = CFG_W'($urandom_range(1, 3));
                    dmax = CFG_W'($urandom_range(0, klen + 1));
                end
                3, 4, 5:
                begin
                    klen = CFG_W'($urandom_range(4, 6));
                    dmax = CFG_W'($urandom_range(0, 3));
                end
                6:
                begin
                    klen = $urandom_range(0, 1) ? 5'd16 : 5'd31;
                    dmax = CFG_W'($urandom_range(0, 1));
                end
                7:
                begin
                    klen = 5'd0;
                    dmax = CFG_W'($urandom);
                end
                8:
                begin
                    klen = CFG_W'($urandom_range(7, 12));
                    dmax = CFG_W'($urandom_range(1, 2));
                end
                default:
                begin
                    klen = CFG_W'($urandom_range(1, 3));
                    dmax = $urandom_range(0, 1) ? 5'd16 : 5'd31;
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_MAX_DISTANCE, dmax);
            else
                set_config(klen, dmax);
            idle_on = ($urandom_range(0, 4) != 0);

            // Sometimes carry on with the old walk under the new settings.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 5)) send_item(KIND_NEXT, $urandom);

            repeat ($urandom_range(2, 8))
            begin
                send_item(KIND_START, pick_kmer());
                cap = ($urandom_range(0, 9) < 7) ? 300 : $urandom_range(0, 12);
                steps = 0;
                while (!walk_done && steps < cap && items_sent < target)
                begin
                    send_item(KIND_NEXT, $urandom);
                    steps++;
                end
                if (walk_done)
                    repeat ($urandom_range(0, 2)) send_item(KIND_NEXT, $urandom);
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_next_before_start();
        test_register_access();
        test_single_base_wide_distance();
        test_zero_length();
        test_saturated_length();
        test_full_length_all_a();
        test_settings_changed_mid_run();
        test_random_runs();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
